[sv/pfa_pkg.sv]
// Package with the word types, operation codes and constants of the prime field unit.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;
  localparam int ElemBits = 31;
  localparam logic [ElemBits-1:0] ModReset = 31'd1234577;

  localparam logic [2:0] OpReduce = 3'd0;
  localparam logic [2:0] OpAdd    = 3'd1;
  localparam logic [2:0] OpSub    = 3'd2;
  localparam logic [2:0] OpMul    = 3'd3;
  localparam logic [2:0] OpDiv    = 3'd4;
  localparam logic [2:0] OpInv    = 3'd5;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [63:0]  a;
    logic [30:0]         b;
  } in_word_t;

  typedef struct packed {
    logic [30:0] result;
    logic        error;
    logic        equal;
    logic        less;
  } out_word_t;

  // Classified job passed from the front to the back part.
  typedef struct packed {
    logic [2:0]          op;
    logic                err;
    logic signed [63:0]  a;
    logic [ElemBits-1:0] b;
    logic                equal;
    logic                less;
  } job_t;
endpackage
`default_nettype wire

[sv/prime_field_alu.sv]
// Top level of the prime field arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic over GF(modulus) for one word at a time. Inverse and divide are computed as a
// chain of modular multiplications, about 62 of them plus one for divide. All products go
// through one 31 by 31 multiplier and a bit-serial remainder. A one-word stage between
// front and back lets the next word be accepted while a result waits. Write cfg only
// while idle.
module prime_field_alu (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pfa_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pfa_pkg::out_word_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_data
);
  logic [pfa_pkg::ElemBits-1:0] mod_r, mod_nxt;
  logic                         job_valid, job_ready;
  pfa_pkg::job_t                job;

  assign cfg_ready = 1'b1;
  always_comb begin
    mod_nxt = mod_r;
    if (cfg_valid && cfg_data[pfa_pkg::ElemBits-1:0] >= pfa_pkg::ElemBits'(3))
      mod_nxt = cfg_data[pfa_pkg::ElemBits-1:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= pfa_pkg::ModReset;
    else mod_r <= mod_nxt;
  end

  pfa_front u_front (.clk, .rst_n, .in_valid, .in_ready, .in_data, .modulus(mod_r),
                     .job_valid, .job_ready, .job);
  pfa_back u_back (.clk, .rst_n, .job_valid, .job_ready, .job, .modulus(mod_r),
                   .out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire

[sv/pfa_front.sv]
// Front part: accepts input words, checks operands and sets the compare flags.
`timescale 1ns / 1ps
`default_nettype none
module pfa_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire pfa_pkg::in_word_t            in_data,
  input  wire logic [pfa_pkg::ElemBits-1:0] modulus,
  output logic                              job_valid,
  input  wire logic                         job_ready,
  output pfa_pkg::job_t                     job
);
  logic                       valid_r, valid_nxt;
  pfa_pkg::job_t              job_r, job_nxt;
  logic [pfa_pkg::ElemBits-1:0] b;
  logic                       neg, a_ok, b_ok;

  assign b    = in_data.b[pfa_pkg::ElemBits-1:0];
  assign neg  = in_data.a[63];
  assign a_ok = !neg && (in_data.a[63:pfa_pkg::ElemBits] == '0) &&
                (in_data.a[pfa_pkg::ElemBits-1:0] < modulus);
  assign b_ok = b < modulus;
  assign in_ready = !valid_r || job_ready;

  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    if (job_ready) valid_nxt = 1'b0;
    if (in_valid && in_ready) begin
      valid_nxt     = 1'b1;
      job_nxt.op    = in_data.op;
      job_nxt.a     = in_data.a;
      job_nxt.b     = b;
      job_nxt.equal = !neg && (in_data.a == {33'd0, b});
      job_nxt.less  = neg || (in_data.a < $signed({33'd0, b}));
      case (in_data.op)
        pfa_pkg::OpReduce: job_nxt.err = 1'b0;
        pfa_pkg::OpAdd, pfa_pkg::OpSub, pfa_pkg::OpMul:
          job_nxt.err = !a_ok || !b_ok;
        pfa_pkg::OpDiv: job_nxt.err = !a_ok || !b_ok || (b == '0);
        pfa_pkg::OpInv: job_nxt.err = !a_ok || (in_data.a == '0);
        default: job_nxt.err = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    job_r <= job_nxt;
  end

  assign job_valid = valid_r;
  assign job       = job_r;
endmodule
`default_nettype wire

[sv/pfa_back.sv]
// Back part: reduce, add, sub, multiply, Fermat inverse and divide on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module pfa_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         job_valid,
  output logic                              job_ready,
  input  wire pfa_pkg::job_t                job,
  input  wire logic [pfa_pkg::ElemBits-1:0] modulus,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output pfa_pkg::out_word_t                out_data
);
  localparam int W = pfa_pkg::ElemBits;
  localparam logic [3:0] SIdle = 4'd0, SRed = 4'd1, SMulA = 4'd2, SMulB = 4'd3,
                         SRedM = 4'd4, SExp = 4'd5, SFin = 4'd6, SOut = 4'd7;

  logic [3:0]        state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic              err_r, err_nxt, eq_r, eq_nxt, lt_r, lt_nxt;
  logic [63:0]       mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [2*W-1:0]    rem_r, rem_nxt;
  logic [W-1:0]      x_r, x_nxt, y_r, y_nxt, base_r, base_nxt, acc_r, acc_nxt;
  logic [W-1:0]      av_r, av_nxt, e_r, e_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [4:0]        ret_r, ret_nxt;
  logic              ovalid_r, ovalid_nxt;
  pfa_pkg::out_word_t odata_r, odata_nxt;

  logic [2*W:0]      rem_sh;
  logic [W:0]        sum;
  logic [W-1:0]      rem_low;
  logic [2*W-1:0]    prod;

  // One restoring step of a bit-serial remainder.
  assign rem_sh  = {rem_r, 1'b0} | {{(2*W){1'b0}}, mag_r[63]};
  assign sum     = {1'b0, x_r} + {1'b0, y_r};
  assign prod    = x_r * y_r;
  assign rem_low = rem_r[W-1:0];
  assign job_ready = (state_r == SIdle);

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; err_nxt = err_r; eq_nxt = eq_r; lt_nxt = lt_r;
    mag_nxt = mag_r; neg_nxt = neg_r; cnt_nxt = cnt_r; rem_nxt = rem_r;
    x_nxt = x_r; y_nxt = y_r; base_nxt = base_r; acc_nxt = acc_r; av_nxt = av_r;
    e_nxt = e_r; phase_nxt = phase_r; ret_nxt = ret_r;
    ovalid_nxt = ovalid_r; odata_nxt = odata_r;
    if (out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      SIdle: if (job_valid) begin
        op_nxt = job.op; err_nxt = job.err; eq_nxt = job.equal; lt_nxt = job.less;
        av_nxt = job.a[W-1:0];
        if (job.err) begin
          acc_nxt = '0; state_nxt = SOut;
        end else begin
          case (job.op)
            pfa_pkg::OpReduce: begin
              neg_nxt = job.a[63];
              mag_nxt = job.a[63] ? 64'(-job.a) : job.a;
              rem_nxt = '0; cnt_nxt = 7'd64; state_nxt = SRed;
            end
            pfa_pkg::OpAdd: begin
              x_nxt = job.a[W-1:0]; y_nxt = job.b; phase_nxt = 2'd0; state_nxt = SMulA;
            end
            pfa_pkg::OpSub: begin
              x_nxt = job.a[W-1:0]; y_nxt = modulus - job.b; phase_nxt = 2'd1;
              state_nxt = SMulA;
            end
            pfa_pkg::OpMul: begin
              x_nxt = job.a[W-1:0]; y_nxt = job.b; phase_nxt = 2'd2; state_nxt = SMulA;
            end
            default: begin
              base_nxt = (job.op == pfa_pkg::OpDiv) ? job.b : job.a[W-1:0];
              acc_nxt = {{(W-1){1'b0}}, 1'b1};
              e_nxt = modulus - W'(2); state_nxt = SExp;
            end
          endcase
        end
      end
      SRed: begin
        if (cnt_r == '0) begin
          acc_nxt = (neg_r && rem_low != '0) ? modulus - rem_low : rem_low;
          state_nxt = SOut;
        end else begin
          rem_nxt = (rem_sh >= {{(W+1){1'b0}}, modulus}) ?
                    (2*W)'(rem_sh - {{(W+1){1'b0}}, modulus}) : (2*W)'(rem_sh);
          mag_nxt = {mag_r[62:0], 1'b0};
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      SMulA: begin
        if (phase_r != 2'd2) begin
          acc_nxt = (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus}) : W'(sum);
          state_nxt = SOut;
        end else begin
          mag_nxt = {prod, {(64-2*W){1'b0}}};
          rem_nxt = '0; cnt_nxt = 7'(2*W); state_nxt = SRedM;
        end
      end
      SRedM: begin
        if (cnt_r == '0) begin
          case (ret_r)
            5'd1: begin acc_nxt = rem_low; state_nxt = SMulB; end
            5'd2: begin base_nxt = rem_low; state_nxt = SExp; end
            5'd3: begin acc_nxt = rem_low; state_nxt = SOut; end
            default: begin acc_nxt = rem_low; state_nxt = SOut; end
          endcase
        end else begin
          rem_nxt = (rem_sh >= {{(W+1){1'b0}}, modulus}) ?
                    (2*W)'(rem_sh - {{(W+1){1'b0}}, modulus}) : (2*W)'(rem_sh);
          mag_nxt = {mag_r[62:0], 1'b0};
          cnt_nxt = cnt_r - 7'd1;
        end
      end
      SMulB: begin
        x_nxt = base_r; y_nxt = base_r; ret_nxt = 5'd2; phase_nxt = 2'd2;
        state_nxt = SMulA;
      end
      SExp: begin
        if (e_r == '0) begin
          if (op_r == pfa_pkg::OpDiv) begin
            x_nxt = av_r; y_nxt = acc_r; ret_nxt = 5'd3; phase_nxt = 2'd2;
            state_nxt = SMulA;
          end else state_nxt = SOut;
        end else begin
          e_nxt = e_r >> 1;
          if (e_r[0]) begin
            x_nxt = acc_r; y_nxt = base_r; ret_nxt = 5'd1;
          end else begin
            x_nxt = base_r; y_nxt = base_r; ret_nxt = 5'd2;
          end
          phase_nxt = 2'd2; state_nxt = SMulA;
        end
      end
      SOut: if (!ovalid_r || out_ready) begin
        ovalid_nxt = 1'b1;
        odata_nxt.result = err_r ? '0 : 31'(acc_r);
        odata_nxt.error = err_r; odata_nxt.equal = eq_r; odata_nxt.less = lt_r;
        ret_nxt = '0; state_nxt = SIdle;
      end
      default: state_nxt = SIdle;
    endcase
    if (state_r == SIdle) ret_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle; ovalid_r <= 1'b0; ret_r <= '0;
    end else begin
      state_r <= state_nxt; ovalid_r <= ovalid_nxt; ret_r <= ret_nxt;
    end
    op_r <= op_nxt; err_r <= err_nxt; eq_r <= eq_nxt; lt_r <= lt_nxt;
    mag_r <= mag_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt; rem_r <= rem_nxt;
    x_r <= x_nxt; y_r <= y_nxt; base_r <= base_nxt; acc_r <= acc_nxt; av_r <= av_nxt;
    e_r <= e_nxt; phase_r <= phase_nxt; odata_r <= odata_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.result == '0) else $error("error with result");
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_data.result < 31'(modulus)) else $error("result not reduced");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
